// ===== rtl/core/tsq_pkg.sv =====
// Shared types, register map and constants for the touch sample qualifier.
package tsq_pkg;

    // Field widths of the raw conversions and timestamps
    localparam int RAW_W  = 12;
    localparam int TIME_W = 32;
    localparam int DEB_W  = 16;
    localparam int NPG_W  = 3;

    // Stream payload widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Queue between front and back
    localparam int Q_DEPTH = 2;

    // Register reset values
    localparam logic [RAW_W-1:0] RST_X_MIN = 12'd460;
    localparam logic [RAW_W-1:0] RST_X_MAX = 12'd3378;
    localparam logic [RAW_W-1:0] RST_Y_MIN = 12'd744;
    localparam logic [RAW_W-1:0] RST_Y_MAX = 12'd3496;
    localparam logic [RAW_W-1:0] RST_P_THR = 12'd300;
    localparam logic [DEB_W-1:0] RST_DEB   = 16'd200;

    // Page action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_PREV = 2'd1;
    localparam logic [1:0] ACT_NEXT = 2'd2;

    // Register index (paddr[4:2])
    typedef enum logic [2:0] {
        REG_X_MIN = 3'd0,
        REG_X_MAX = 3'd1,
        REG_Y_MIN = 3'd2,
        REG_Y_MAX = 3'd3,
        REG_P_THR = 3'd4,
        REG_DEB   = 3'd5
    } t_reg_idx;

    // Calibration and qualification settings
    typedef struct packed {
        logic [RAW_W-1:0] x_min;
        logic [RAW_W-1:0] x_max;
        logic [RAW_W-1:0] y_min;
        logic [RAW_W-1:0] y_max;
        logic [RAW_W-1:0] p_thr;
        logic [DEB_W-1:0] deb;
    } t_cfg;

    // What the back end has to do with an item
    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REJECT = 2'd1,
        OP_MAP    = 2'd2
    } t_op;

    // One queued item
    typedef struct packed {
        t_op              op;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic [NPG_W-1:0] new_page;
    } t_qent;

    // Queue status toward the back end
    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

    // Back end sequencer
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_EMIT = 2'd2
    } t_bstate;

endpackage

// ===== rtl/core/tsq_front.sv =====
// Front end: takes input transfers, qualifies touch samples, tracks debounce time.
module tsq_front
    import tsq_pkg::*;
#(
    parameter int PAGE_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [0] pen_down, [12:1] raw_x, [24:13] raw_y, [36:25] raw_pressure,
    // [68:37] time_ms, [71:69] new_page
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [0] kind
    input  logic                i_s_tuser,
    input  t_cfg                i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output t_qent               o_ent
);

    localparam logic [NPG_W-1:0] LAST_PAGE = NPG_W'(PAGE_COUNT - 1);

    logic [TIME_W-1:0] r_last_ms;
    logic [TIME_W-1:0] n_last_ms;

    logic              pen;
    logic [RAW_W-1:0]  raw_p;
    logic [TIME_W-1:0] t_ms;
    logic [NPG_W-1:0]  np;
    logic [TIME_W-1:0] gap;
    logic              qualify;
    logic              xfer;

    assign pen   = i_s_tdata[0];
    assign raw_p = i_s_tdata[36:25];
    assign t_ms  = i_s_tdata[68:37];
    assign np    = i_s_tdata[71:69];

    assign o_s_tready = !i_q_full;
    assign xfer       = i_s_tvalid && o_s_tready;
    assign o_push     = xfer;

    // Gap since last accepted touch, modulo 2^32
    assign gap     = t_ms - r_last_ms;
    assign qualify = pen && (raw_p > i_cfg.p_thr) && (gap > TIME_W'(i_cfg.deb));

    // Classify the item
    always_comb begin
        o_ent.raw_x    = i_s_tdata[12:1];
        o_ent.raw_y    = i_s_tdata[24:13];
        o_ent.new_page = (np > LAST_PAGE) ? LAST_PAGE : np;
        n_last_ms      = r_last_ms;
        if (i_s_tuser) begin
            o_ent.op = OP_SET;
        end else if (qualify) begin
            o_ent.op = OP_MAP;
            if (xfer) begin
                n_last_ms = t_ms;
            end
        end else begin
            o_ent.op = OP_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms <= '0;
        end else begin
            r_last_ms <= n_last_ms;
        end
    end

endmodule

// ===== rtl/core/tsq_queue.sv =====
// Short in-order queue between the front and back ends.
module tsq_queue
    import tsq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_ent,
    input  logic   i_pop,
    output t_qent  o_ent,
    output t_qstat o_stat
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_qent          r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic [QAW-1:0] n_wp;
    logic [QAW-1:0] n_rp;
    logic [QCW-1:0] n_cnt;

    assign o_ent        = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == QCW'(Q_DEPTH));

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QAW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QAW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_stat.valid))
        else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/tsq_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module tsq_div #(
    parameter int DW = 21,
    parameter int VW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quo
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;

    // One trial subtraction
    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : shifted[VW-1:0];
        end
    end

endmodule

// ===== rtl/core/tsq_back.sv =====
// Back end: maps accepted samples to pixels, steps the page, drives results.
module tsq_back
    import tsq_pkg::*;
#(
    parameter int SCREEN_W   = 320,
    parameter int SCREEN_H   = 240,
    parameter int PAGE_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_qstat              i_qstat,
    input  t_qent               i_ent,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [0] accepted, [9:1] screen_x, [17:10] screen_y, [19:18] page_action,
    // [22:20] page, [23] zero
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int XW  = $clog2(SCREEN_W);
    localparam int YW  = $clog2(SCREEN_H);
    localparam int PW  = $clog2(PAGE_COUNT);
    localparam int XDW = RAW_W + $clog2(SCREEN_W + 1);
    localparam int YDW = RAW_W + $clog2(SCREEN_H + 1);

    localparam logic [XW-1:0] LEFT_LIM  = XW'((SCREEN_W + 2) / 3);
    localparam logic [XW-1:0] RIGHT_LIM = XW'((2 * SCREEN_W) / 3);
    localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);

    t_bstate r_state;
    t_bstate n_state;

    t_qent          r_ent;
    logic           r_z_x;
    logic           r_z_y;
    logic [PW-1:0]  r_page;
    logic [XW-1:0]  r_held_x;
    logic [YW-1:0]  r_held_y;
    logic           r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic [PW-1:0]  n_page;
    logic [XW-1:0]  n_held_x;
    logic [YW-1:0]  n_held_y;
    logic           n_acc;
    logic [1:0]     n_act;

    logic           out_free;
    logic           div_start;
    logic           emit;

    // Per-axis setup
    logic signed [RAW_W:0] num_x, span_x, num_y, span_y;
    logic [RAW_W-1:0]      mag_nx, mag_sx, mag_ny, mag_sy;
    logic [XDW-1:0]        dvd_x;
    logic [YDW-1:0]        dvd_y;
    logic                  z_x, z_y;
    logic                  busy_x, busy_y;
    logic [XDW-1:0]        quo_x;
    logic [YDW-1:0]        quo_y;
    logic [XW-1:0]         map_x;
    logic [YW-1:0]         map_y;

    // Output field extension
    logic [XW+8:0]         ext_x;
    logic [YW+7:0]         ext_y;
    logic [PW+2:0]         ext_p;

    // Signed offsets and spans; division runs on magnitudes
    always_comb begin
        num_x  = $signed({1'b0, i_ent.raw_x}) - $signed({1'b0, i_cfg.x_min});
        span_x = $signed({1'b0, i_cfg.x_max}) - $signed({1'b0, i_cfg.x_min});
        num_y  = $signed({1'b0, i_ent.raw_y}) - $signed({1'b0, i_cfg.y_min});
        span_y = $signed({1'b0, i_cfg.y_max}) - $signed({1'b0, i_cfg.y_min});
        mag_nx = num_x[RAW_W]  ? RAW_W'(-num_x)  : num_x[RAW_W-1:0];
        mag_sx = span_x[RAW_W] ? RAW_W'(-span_x) : span_x[RAW_W-1:0];
        mag_ny = num_y[RAW_W]  ? RAW_W'(-num_y)  : num_y[RAW_W-1:0];
        mag_sy = span_y[RAW_W] ? RAW_W'(-span_y) : span_y[RAW_W-1:0];
        dvd_x  = XDW'(mag_nx) * XDW'(SCREEN_W);
        dvd_y  = YDW'(mag_ny) * YDW'(SCREEN_H);
        // Zero span, or opposite signs: result clamps to zero
        z_x    = (span_x == '0) || (num_x[RAW_W] != span_x[RAW_W]);
        z_y    = (span_y == '0) || (num_y[RAW_W] != span_y[RAW_W]);
    end

    tsq_div #(.DW(XDW), .VW(RAW_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_x),
        .i_divisor  (mag_sx),
        .o_busy     (busy_x),
        .o_quo      (quo_x)
    );

    tsq_div #(.DW(YDW), .VW(RAW_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_y),
        .i_divisor  (mag_sy),
        .o_busy     (busy_y),
        .o_quo      (quo_y)
    );

    // Clamp quotients to the screen
    always_comb begin
        if (r_z_x) begin
            map_x = '0;
        end else if (quo_x > XDW'(SCREEN_W - 1)) begin
            map_x = XW'(SCREEN_W - 1);
        end else begin
            map_x = quo_x[XW-1:0];
        end
        if (r_z_y) begin
            map_y = '0;
        end else if (quo_y > YDW'(SCREEN_H - 1)) begin
            map_y = YW'(SCREEN_H - 1);
        end else begin
            map_y = quo_y[YW-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_qstat.valid) begin
                    n_state = (i_ent.op == OP_MAP) ? S_DIV : S_EMIT;
                end
            end
            S_DIV: begin
                if (!busy_x && !busy_y) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    assign out_free = !r_out_valid || i_m_tready;
    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop     = i_qstat.valid;
                div_start = i_qstat.valid && (i_ent.op == OP_MAP);
            end
            S_DIV: begin
            end
            S_EMIT: begin
                emit = out_free;
            end
            default: begin
            end
        endcase
    end

    // Result and state update for the item in hand
    always_comb begin
        n_page   = r_page;
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        n_acc    = 1'b0;
        n_act    = ACT_NONE;
        case (r_ent.op)
            OP_SET: begin
                n_page = r_ent.new_page[PW-1:0];
            end
            OP_MAP: begin
                n_acc    = 1'b1;
                n_held_x = map_x;
                n_held_y = map_y;
                if (map_x < LEFT_LIM) begin
                    n_act  = ACT_PREV;
                    n_page = (r_page == '0) ? LAST_PAGE : r_page - 1'b1;
                end else if (map_x > RIGHT_LIM) begin
                    n_act  = ACT_NEXT;
                    n_page = (r_page == LAST_PAGE) ? '0 : r_page + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign ext_x = {9'b0, n_held_x};
    assign ext_y = {8'b0, n_held_y};
    assign ext_p = {3'b0, n_page};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_page      <= '0;
            r_held_x    <= '0;
            r_held_y    <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
                r_page      <= n_page;
                r_held_x    <= n_held_x;
                r_held_y    <= n_held_y;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_ent;
            r_z_x <= z_x;
            r_z_y <= z_y;
        end
        if (emit) begin
            r_out_data <= {1'b0, ext_p[2:0], n_act, ext_y[7:0], ext_x[8:0], n_acc};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_div_only_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ent.op == OP_MAP))
        else $error("divide phase on a non-mapping item");
    a_emit_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!busy_x && !busy_y))
        else $error("result emitted while dividers busy");
    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page <= LAST_PAGE)
        else $error("page out of range");
`endif

endmodule

// ===== rtl/core/touch_sample_qualify_map_page.sv =====
// Top level: touch sample qualifier with calibrated mapping and page stepping.
//
//   channel   dir  handshake                 payload
//   s stream  in   i_s_tvalid / o_s_tready   i_s_tdata (72b), i_s_tuser (kind)
//   m stream  out  o_m_tvalid / i_m_tready   o_m_tdata (24b)
//   apb cfg   in   psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A mapping sample goes from transfer through the queue and the bit-serial dividers, which run
// X and Y side by side, to the output register.
// Rejected samples and page writes skip the dividers.
// A two-entry queue lets the front keep taking transfers while the back divides
// or the output register waits on i_m_tready.
// Synchronous active-low reset; no clearing pass is needed.
module touch_sample_qualify_map_page
    import tsq_pkg::*;
#(
    parameter int SCREEN_W   = 320,
    parameter int SCREEN_H   = 240,
    parameter int PAGE_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [0] pen_down, [12:1] raw_x, [24:13] raw_y, [36:25] raw_pressure,
    // [68:37] time_ms, [71:69] new_page
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [0] kind
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [0] accepted, [9:1] screen_x, [17:10] screen_y, [19:18] page_action,
    // [22:20] page, [23] zero
    output logic [M_DATA_W-1:0] o_m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     push;
    logic     pop;
    t_qent    ent_in;
    t_qent    ent_out;
    t_qstat   qstat;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min <= RST_X_MIN;
            r_cfg.x_max <= RST_X_MAX;
            r_cfg.y_min <= RST_Y_MIN;
            r_cfg.y_max <= RST_Y_MAX;
            r_cfg.p_thr <= RST_P_THR;
            r_cfg.deb   <= RST_DEB;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_X_MIN: r_cfg.x_min <= pwdata[RAW_W-1:0];
                REG_X_MAX: r_cfg.x_max <= pwdata[RAW_W-1:0];
                REG_Y_MIN: r_cfg.y_min <= pwdata[RAW_W-1:0];
                REG_Y_MAX: r_cfg.y_max <= pwdata[RAW_W-1:0];
                REG_P_THR: r_cfg.p_thr <= pwdata[RAW_W-1:0];
                REG_DEB:   r_cfg.deb   <= pwdata[DEB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_X_MIN: prdata = APB_DW'(r_cfg.x_min);
            REG_X_MAX: prdata = APB_DW'(r_cfg.x_max);
            REG_Y_MIN: prdata = APB_DW'(r_cfg.y_min);
            REG_Y_MAX: prdata = APB_DW'(r_cfg.y_max);
            REG_P_THR: prdata = APB_DW'(r_cfg.p_thr);
            REG_DEB:   prdata = APB_DW'(r_cfg.deb);
            default:   prdata = '0;
        endcase
    end

    tsq_front #(.PAGE_COUNT(PAGE_COUNT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg      (r_cfg),
        .i_q_full   (qstat.full),
        .o_push     (push),
        .o_ent      (ent_in)
    );

    tsq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (ent_in),
        .i_pop   (pop),
        .o_ent   (ent_out),
        .o_stat  (qstat)
    );

    tsq_back #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_qstat    (qstat),
        .i_ent      (ent_out),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== tb/tb_touch_sample_qualify_map_page.sv =====
// Self-checking testbench for the touch sample qualifier: predicts each result and compares it.
`timescale 1ns / 1ps

module tb_touch_sample_qualify_map_page;
    import tsq_pkg::*;

    localparam int SCREEN_W   = 320;
    localparam int SCREEN_H   = 240;
    localparam int PAGE_COUNT = 4;
    localparam int LEFT_EDGE  = (SCREEN_W + 2) / 3;
    localparam int RIGHT_EDGE = (2 * SCREEN_W) / 3;

    // tuser codes
    localparam logic KIND_TOUCH = 1'b0;
    localparam logic KIND_SET   = 1'b1;

    // addresses past the register list, writes must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 240;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // input transfer layout, lowest field last
    typedef struct packed {
        logic [2:0]  new_page;
        logic [31:0] time_ms;
        logic [11:0] pressure;
        logic [11:0] raw_y;
        logic [11:0] raw_x;
        logic        pen;
    } t_touch_sample;

    // output transfer layout, lowest field last
    typedef struct packed {
        logic       pad;
        logic [2:0] page;
        logic [1:0] action;
        logic [7:0] pix_y;
        logic [8:0] pix_x;
        logic       accepted;
    } t_touch_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic                i_s_tuser  = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    touch_sample_qualify_map_page #(
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .PAGE_COUNT(PAGE_COUNT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Predictor state: register shadow plus the block's own state
    logic [31:0]   reg_shadow [6];
    int unsigned   page_cur;
    logic [31:0]   last_touch_ms;
    int unsigned   hold_x;
    int unsigned   hold_y;

    t_touch_result expected_results [$];
    int unsigned   err_count    = 0;
    int unsigned   cycle_count  = 0;
    logic [31:0]   stamp_ms;
    bit            tx_gaps_on   = 1'b1;
    bit            rx_stalls_on = 1'b1;
    int unsigned   stall_left   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Linear calibration onto one screen axis, truncating division, clamped
    function automatic int unsigned scale_to_pixel(input logic [11:0] raw,
                                                   input logic [11:0] lo,
                                                   input logic [11:0] hi,
                                                   input int size);
        longint span;
        longint v;
        span = longint'(hi) - longint'(lo);
        if (span == 0) return 0;
        v = ((longint'(raw) - longint'(lo)) * size) / span;
        if (v < 0) v = 0;
        if (v > size - 1) v = size - 1;
        return int'(v);
    endfunction

    // Advance the qualifier state by one item and return what it reports
    function automatic t_touch_result predict_touch(input logic kind, input t_touch_sample s);
        t_touch_result r;
        logic [31:0]   gap;
        r   = '0;
        gap = s.time_ms - last_touch_ms;
        if (kind == KIND_SET) begin
            page_cur = (s.new_page > PAGE_COUNT - 1) ? PAGE_COUNT - 1 : s.new_page;
        end else if (s.pen && s.pressure > reg_shadow[REG_P_THR][11:0] &&
                     gap > {16'd0, reg_shadow[REG_DEB][15:0]}) begin
            r.accepted    = 1'b1;
            last_touch_ms = s.time_ms;
            hold_x = scale_to_pixel(s.raw_x, reg_shadow[REG_X_MIN][11:0],
                                    reg_shadow[REG_X_MAX][11:0], SCREEN_W);
            hold_y = scale_to_pixel(s.raw_y, reg_shadow[REG_Y_MIN][11:0],
                                    reg_shadow[REG_Y_MAX][11:0], SCREEN_H);
            if (hold_x < LEFT_EDGE) begin
                r.action = ACT_PREV;
                page_cur = (page_cur == 0) ? PAGE_COUNT - 1 : page_cur - 1;
            end else if (hold_x > RIGHT_EDGE) begin
                r.action = ACT_NEXT;
                page_cur = (page_cur + 1 >= PAGE_COUNT) ? 0 : page_cur + 1;
            end
        end
        r.pix_x = hold_x[8:0];
        r.pix_y = hold_y[7:0];
        r.page  = page_cur[2:0];
        return r;
    endfunction

    function automatic t_touch_sample make_sample(input logic pen, input int unsigned x,
                                                  input int unsigned y, input int unsigned p,
                                                  input logic [31:0] t, input int unsigned np);
        t_touch_sample s;
        s.pen      = pen;
        s.raw_x    = x[11:0];
        s.raw_y    = y[11:0];
        s.pressure = p[11:0];
        s.time_ms  = t;
        s.new_page = np[2:0];
        return s;
    endfunction

    // One input transfer; valid stays high afterward so items can go back to back
    task automatic send_sample(input logic kind, input t_touch_sample s);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        expected_results.push_back(predict_touch(kind, s));
    endtask

    // Stop the stream and wait until every result is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // APB write: setup then access, committed at the access edge with pready
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX, REG_P_THR: begin
                reg_shadow[idx] = value & 32'h0000_0FFF;
            end
            REG_DEB: begin
                reg_shadow[idx] = value & 32'h0000_FFFF;
            end
            default: ;
        endcase
    endtask

    // APB read of every register, compared with the shadow
    task automatic check_registers();
        for (int i = REG_X_MIN; i <= REG_DEB; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(i), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== reg_shadow[i]) begin
                $error("register %0d: expected %0h, actual %0h", i, reg_shadow[i], prdata);
                err_count++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    // Result side: compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_touch_result got;
        t_touch_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (expected_results.size() == 0) begin
                $error("result transfer %h with nothing expected", o_m_tdata);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("screen_x", want.pix_x, got.pix_x);
                check_field("screen_y", want.pix_y, got.pix_y);
                check_field("page_action", want.action, got.action);
                check_field("page", want.page, got.page);
                check_field("reserved", want.pad, got.pad);
            end
        end
    end

    // Receiver backpressure: random stalls on i_m_tready
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_register_reset_values();
        check_registers();
    endtask

    // Qualification rules, mapping clamps, third boundaries and page wrap
    task automatic test_touch_qualify_and_paging();
        send_sample(KIND_TOUCH, make_sample(1'b0, 2000, 2000, 4095, 1000, 0));  // pen up
        send_sample(KIND_TOUCH, make_sample(1'b1, 2000, 2000, 300, 1000, 0));   // at threshold
        send_sample(KIND_TOUCH, make_sample(1'b1, 2000, 2000, 301, 200, 0));    // gap equals debounce
        send_sample(KIND_TOUCH, make_sample(1'b1, 460, 744, 301, 201, 0));      // left, wraps back
        send_sample(KIND_TOUCH, make_sample(1'b1, 4095, 2000, 301, 401, 0));    // still bouncing
        send_sample(KIND_TOUCH, make_sample(1'b1, 4095, 2000, 301, 402, 0));    // right, wraps fwd
        send_sample(KIND_TOUCH, make_sample(1'b1, 1919, 0, 4095, 700, 0));      // middle, y low clamp
        send_sample(KIND_TOUCH, make_sample(1'b1, 1435, 4095, 1000, 1000, 0));  // last left pixel
        send_sample(KIND_TOUCH, make_sample(1'b1, 1436, 4095, 1000, 1300, 0));  // first middle pixel
        send_sample(KIND_TOUCH, make_sample(1'b1, 2403, 1000, 1000, 1600, 0));  // last middle pixel
        send_sample(KIND_TOUCH, make_sample(1'b1, 2412, 1000, 1000, 1900, 0));  // first right pixel
        send_sample(KIND_TOUCH, make_sample(1'b1, 0, 0, 0, 2500, 0));           // all zero fields
        // page writes ignore the touch fields; out-of-range pages saturate
        send_sample(KIND_SET, make_sample(1'b1, 3000, 3000, 4095, 9000, 7));
        send_sample(KIND_SET, make_sample(1'b0, 0, 0, 0, 0, 2));
        send_sample(KIND_SET, make_sample(1'b1, 4095, 4095, 4095, 32'hFFFF_FFFF, 4));
        send_sample(KIND_SET, make_sample(1'b0, 0, 0, 0, 0, 0));
        // all ones, then a timestamp that wraps past zero
        send_sample(KIND_TOUCH, make_sample(1'b1, 4095, 4095, 4095, 32'hFFFF_FFFF, 7));
        send_sample(KIND_TOUCH, make_sample(1'b1, 1900, 2000, 2000, 32'h0000_0010, 5));
        send_sample(KIND_TOUCH, make_sample(1'b1, 1900, 2000, 2000, 32'h0000_00D8, 5));
        drain_results();
        stamp_ms = 32'h0000_1000;
    endtask

    // Equal, reversed and full-range bounds; threshold and debounce extremes
    task automatic test_calibration_corners();
        write_reg(REG_X_MIN, 32'd2048);
        write_reg(REG_X_MAX, 32'd2048);
        write_reg(REG_Y_MIN, 32'd0);
        write_reg(REG_Y_MAX, 32'd4095);
        write_reg(REG_P_THR, 32'd0);
        write_reg(REG_DEB, 32'd0);
        check_registers();
        send_sample(KIND_TOUCH, make_sample(1'b1, 4095, 4095, 0, stamp_ms + 5, 0));
        send_sample(KIND_TOUCH, make_sample(1'b1, 4095, 4095, 1, stamp_ms + 5, 0));
        send_sample(KIND_TOUCH, make_sample(1'b1, 100, 0, 1, stamp_ms + 6, 0));
        drain_results();

        write_reg(REG_X_MIN, 32'hFFFF_FFFF);
        write_reg(REG_X_MAX, 32'd0);
        write_reg(REG_Y_MIN, 32'd3000);
        write_reg(REG_Y_MAX, 32'd100);
        write_reg(REG_P_THR, 32'd4095);
        write_reg(REG_DEB, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_A, 32'h0000_0123);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        check_registers();
        send_sample(KIND_TOUCH, make_sample(1'b1, 1000, 1000, 4095, stamp_ms + 32'h2_0000, 0));
        drain_results();
        write_reg(REG_P_THR, 32'd4094);
        send_sample(KIND_TOUCH, make_sample(1'b1, 1000, 1000, 4095, stamp_ms + 32'h2_0000, 0));
        send_sample(KIND_TOUCH, make_sample(1'b1, 3500, 200, 4095, stamp_ms + 32'h2_FFFF, 0));
        send_sample(KIND_TOUCH, make_sample(1'b1, 0, 3800, 4095, stamp_ms + 32'h4_0000, 0));
        drain_results();
        stamp_ms = stamp_ms + 32'h4_0000;
    endtask

    // One raw calibration pair: mostly ordered, sometimes equal or reversed
    task automatic write_random_bounds(input logic [2:0] lo_idx, input logic [2:0] hi_idx);
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(0, 7);
        lo   = $urandom_range(0, 1500);
        hi   = $urandom_range(2500, 4095);
        if (pick == 0) hi = lo;
        if (pick == 1) begin
            write_reg(lo_idx, {20'($urandom_range(0, 255)), 12'(hi)});
            write_reg(hi_idx, lo);
        end else begin
            write_reg(lo_idx, {20'($urandom_range(0, 255)), 12'(lo)});
            write_reg(hi_idx, hi);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned   sel;
        int unsigned   thr;
        int unsigned   deb;
        logic          kind;
        t_touch_sample s;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_random_bounds(REG_X_MIN, REG_X_MAX);
            write_random_bounds(REG_Y_MIN, REG_Y_MAX);
            sel = $urandom_range(0, 7);
            thr = (sel < 2) ? $urandom_range(0, 4095) : $urandom_range(0, 800);
            if (sel == 7) thr = 0;
            write_reg(REG_P_THR, {16'($urandom_range(0, 65535)), 4'(0), 12'(thr)});
            sel = $urandom_range(0, 7);
            deb = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 1000);
            write_reg(REG_DEB, {16'($urandom_range(0, 65535)), 16'(deb)});
            check_registers();
            // the last phase runs both sides flat out
            if (phase == RANDOM_PHASES - 1) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = ($urandom_range(0, 9) == 0) ? KIND_SET : KIND_TOUCH;
                sel  = $urandom_range(0, 15);
                if (sel == 0) stamp_ms = $urandom;
                else if (sel < 4) stamp_ms = stamp_ms + $urandom_range(0, deb);
                else stamp_ms = stamp_ms + deb + $urandom_range(1, 300);
                s.pen      = ($urandom_range(0, 9) != 0);
                s.raw_x    = 12'($urandom_range(0, 4095));
                s.raw_y    = 12'($urandom_range(0, 4095));
                s.pressure = ($urandom_range(0, 3) != 0 && thr < 4095) ?
                             12'($urandom_range(thr + 1, 4095)) : 12'($urandom_range(0, 4095));
                s.time_ms  = stamp_ms;
                s.new_page = 3'($urandom_range(0, 7));
                send_sample(kind, s);
            end
            drain_results();
        end
    endtask

    initial begin
        reg_shadow[REG_X_MIN] = RST_X_MIN;
        reg_shadow[REG_X_MAX] = RST_X_MAX;
        reg_shadow[REG_Y_MIN] = RST_Y_MIN;
        reg_shadow[REG_Y_MAX] = RST_Y_MAX;
        reg_shadow[REG_P_THR] = RST_P_THR;
        reg_shadow[REG_DEB]   = RST_DEB;
        page_cur      = 0;
        last_touch_ms = '0;
        hold_x        = 0;
        hold_y        = 0;
        stamp_ms      = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset_values();
        test_touch_qualify_and_paging();
        test_calibration_corners();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
